// ===== rtl/deq_pkg.sv =====
// deq_pkg: shared types and constants of the double-ended queue
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	// ring depth, a power of two so that slot arithmetic wraps by truncation
	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = 8;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_READ       = 3'd6,
		OP_WRITE      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_req;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/deq_if.sv =====
// deq_if: request and response channel interfaces of the double-ended queue
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
	logic                       valid;
	logic                       ready;
	deq_pkg::op_t               operation;
	logic signed [31:0]         value;
	logic [7:0]                 index;

	modport source (output valid, output operation, output value, output index, input ready);
	modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

interface deq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic signed [31:0]         data;
	deq_pkg::status_t           status;
	logic [8:0]                 occupancy;

	modport source (output valid, output data, output status, output occupancy, input ready);
	modport sink   (input valid, input data, input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// deq_ctrl: request/response sequencer of the double-ended queue
// depends on deq_pkg; drives the datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output deq_pkg::cmd_t      cmd
);
	import deq_pkg::*;

	fsm_t state_q;
	fsm_t state_n;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n      = state_q;
		req_ready    = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_n      = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				// result register free or draining this cycle
				if (!out_valid_q || rsp_ready) begin
					cmd.exec = 1'b1;
					state_n  = FSM_IDLE;
				end
			end
			default: begin
				state_n = FSM_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/deq_dpath.sv =====
// deq_dpath: ring storage, front pointer, count and result registers
// depends on deq_pkg; sequenced by deq_ctrl through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module deq_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire deq_pkg::cmd_t               cmd,
	input  wire deq_pkg::op_t                operation,
	input  wire logic signed [deq_pkg::VAL_W-1:0] value,
	input  wire logic [deq_pkg::IDX_W-1:0]   index,
	output logic signed [deq_pkg::VAL_W-1:0] data,
	output deq_pkg::status_t                 status,
	output logic [deq_pkg::CNT_W-1:0]        occupancy
);
	import deq_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];

	op_t              op_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;
	logic [PTR_W-1:0] fp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] rd_q;
	logic             data_en_q;
	status_t          status_q;

	logic [PTR_W-1:0] addr;
	logic [PTR_W-1:0] fp_n;
	logic [CNT_W-1:0] cnt_n;
	status_t          status_n;
	logic             we;
	logic             data_en_n;
	logic             is_full;
	logic             is_empty;
	logic             in_range;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= operation;
			val_q <= value;
			idx_q <= index;
		end
	end

	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign in_range = (CNT_W'(idx_q) < cnt_q);

	always_comb begin
		addr      = fp_q;
		fp_n      = fp_q;
		cnt_n     = cnt_q;
		status_n  = ST_OK;
		we        = 1'b0;
		data_en_n = 1'b0;
		case (op_q)
			OP_PUSH_FRONT: begin
				addr = fp_q - PTR_W'(1);
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					we    = 1'b1;
					fp_n  = addr;
					cnt_n = cnt_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				addr = fp_q + cnt_q[PTR_W-1:0];
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					we    = 1'b1;
					cnt_n = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				addr = fp_q;
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					data_en_n = 1'b1;
					fp_n      = fp_q + PTR_W'(1);
					cnt_n     = cnt_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				addr = fp_q + cnt_q[PTR_W-1:0] - PTR_W'(1);
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					data_en_n = 1'b1;
					cnt_n     = cnt_q - CNT_W'(1);
				end
			end
			OP_PEEK_FRONT: begin
				addr = fp_q;
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					data_en_n = 1'b1;
				end
			end
			OP_PEEK_BACK: begin
				addr = fp_q + cnt_q[PTR_W-1:0] - PTR_W'(1);
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					data_en_n = 1'b1;
				end
			end
			OP_READ: begin
				addr = fp_q + PTR_W'(idx_q);
				if (!in_range) begin
					status_n = ST_RANGE;
				end else begin
					data_en_n = 1'b1;
				end
			end
			OP_WRITE: begin
				addr = fp_q + PTR_W'(idx_q);
				if (!in_range) begin
					status_n = ST_RANGE;
				end else begin
					we = 1'b1;
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	// ring storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (we) begin
				mem_q[addr] <= val_q;
			end
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.exec) begin
			fp_q  <= fp_n;
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= status_n;
			data_en_q <= data_en_n;
		end
	end

	assign data      = data_en_q ? rd_q : '0;
	assign status    = status_q;
	assign occupancy = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_top.sv =====
// double_ended_queue_top: top level of the double-ended queue
// depends on deq_pkg, deq_if, deq_ctrl and deq_dpath
`timescale 1ns / 1ps
`default_nettype none

// A bounded double-ended queue of 256 signed 32-bit words kept in a ring
// buffer with a front pointer and a count. Each request item carries one
// operation (push front/back, pop front/back, peek front/back, read or write
// at an index counted from the front) and returns exactly one response item
// with the data word, a status (ok, empty, full, index out of range) and the
// occupancy after the request. Data is zero for pushes, writes and failed
// requests. A request is first captured in the request registers, then waits
// in the execute state until the output register is free or draining, and
// then makes the single-port ring memory access whose registered read feeds
// the response. The next request is taken while a response still waits in
// the output register. No clearing pass follows reset; storage outside the
// count is never returned as data.
module double_ended_queue_top (
	input  wire logic clk,
	input  wire logic arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	cmd_t cmd;

	// sequencer: request capture, memory cycle, response hold
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// ring storage and pointers
	deq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (req.operation),
		.value     (req.value),
		.index     (req.index),
		.data      (rsp.data),
		.status    (rsp.status),
		.occupancy (rsp.occupancy)
	);

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
// deq_checker: port-level assertions for the double-ended queue
// depends on deq_pkg; bound to double_ended_queue_top
`timescale 1ns / 1ps
`default_nettype none

module deq_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   rsp_valid,
	input wire logic                   rsp_ready,
	input wire logic signed [31:0]     rsp_data,
	input wire deq_pkg::status_t       rsp_status,
	input wire logic [8:0]             rsp_occupancy
);
	import deq_pkg::*;

	// occupancy never exceeds the ring depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy above depth");

	// failed requests return zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_OK) |-> (rsp_data == '0))
		else $error("nonzero data on failed item");

	// full only reported at full occupancy, empty only at zero
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
		else $error("full status below depth");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
		else $error("empty status with stored words");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)
			&& $stable(rsp_status) && $stable(rsp_occupancy)))
		else $error("stalled response changed");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_data      (rsp.data),
	.rsp_status    (rsp.status),
	.rsp_occupancy (rsp.occupancy)
);

`default_nettype wire
